>>> rtl/sqv_pkg.sv
package sqv_pkg;

    // Quarter-wave sine coefficients, Q30: c1, c3, c5, c7, c9.
    localparam logic [30:0] COEF_C1 = 31'd1686629713;
    localparam logic [30:0] COEF_C3 = 31'd693598668;
    localparam logic [30:0] COEF_C5 = 31'd85569306;
    localparam logic [30:0] COEF_C7 = 31'd5026995;
    localparam logic [30:0] COEF_C9 = 31'd172272;

    // Horner steps in the order they are applied.
    localparam logic [30:0] HORNER_COEF [4] = '{COEF_C7, COEF_C5, COEF_C3, COEF_C1};

    localparam logic [16:0] PIVOT_ONE = 17'h10000;
    localparam logic [1:0]  CORNER_TR = 2'd3;

    // Sprite after the first stage: pivot offsets computed.
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [23:0]        w;
        logic [23:0]        h;
        logic [23:0]        ox;
        logic [23:0]        oy;
        logic [16:0]        depth;
        logic [31:0]        ttl;
        logic [31:0]        tbr;
        logic [31:0]        col;
    } s1_t;

    // Sprite with corner offsets relative to the pivot.
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [24:0] xl;
        logic signed [24:0] xr;
        logic signed [24:0] yt;
        logic signed [24:0] yb;
        logic [16:0]        depth;
        logic [31:0]        ttl;
        logic [31:0]        tbr;
        logic [31:0]        col;
    } spr_t;

    // Per-vertex fields that ride along with the rotation.
    typedef struct packed {
        logic [16:0] depth;
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] col;
        logic [1:0]  corner;
        logic        last;
    } side_t;

endpackage

>>> rtl/sqv_sincos.sv
module sqv_sincos #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [15:0]                 angle,
    output logic signed [TRIG_BITS-1:0] value
);

    localparam int F = TRIG_BITS - 2;
    localparam logic [31:0] RND = 32'(1) << (29 - F);
    localparam logic [30:0] Q30_ONE = 31'h40000000;
    localparam logic [30:0] COEF_C9_L = sqv_pkg::COEF_C9;

    logic [14:0] k;
    logic [30:0] t;
    logic [61:0] tt;

    logic [30:0] t_reg  [5];
    logic [30:0] t2_reg [4];
    logic        neg_reg [5];
    logic [30:0] p_reg  [4];
    logic [61:0] prod   [4];
    logic [30:0] pin    [4];

    logic [61:0] fprod;
    logic [31:0] pq;
    logic [30:0] pc;
    logic [31:0] rs;
    logic [F:0]  mag;
    logic signed [TRIG_BITS-1:0] value_reg;
    logic signed [TRIG_BITS-1:0] value_next;

    // Odd quadrants mirror the quarter wave.
    assign k  = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign t  = {k, 16'b0};
    assign tt = 62'(t) * 62'(t);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pin[j]  = (j == 0) ? COEF_C9_L : p_reg[(j == 0) ? 0 : j - 1];
            prod[j] = 62'(t2_reg[j]) * 62'(pin[j]);
        end
    end

    assign fprod = 62'(t_reg[4]) * 62'(p_reg[3]);
    assign pq    = fprod[61:30];
    assign pc    = (pq > 32'(Q30_ONE)) ? Q30_ONE : pq[30:0];
    assign rs    = (32'(pc) + RND) >> (30 - F);
    assign mag   = rs[F:0];
    assign value_next = neg_reg[4] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]   <= t;
            t2_reg[0]  <= tt[60:30];
            neg_reg[0] <= angle[15];
            for (int j = 0; j < 4; j++)
            begin
                p_reg[j]     <= sqv_pkg::HORNER_COEF[j] - prod[j][60:30];
                t_reg[j+1]   <= t_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            for (int j = 1; j < 4; j++)
            begin
                t2_reg[j] <= t2_reg[j-1];
            end
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

>>> rtl/sqv_rotate.sv
module sqv_rotate #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vin_valid,
    output logic                        vin_ready,
    input  logic signed [24:0]          dx,
    input  logic signed [24:0]          dy,
    input  logic signed [TRIG_BITS-1:0] sin_v,
    input  logic signed [TRIG_BITS-1:0] cos_v,
    input  logic signed [23:0]          cx,
    input  logic signed [23:0]          cy,
    input  sqv_pkg::side_t              side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [23:0]          vert_x,
    output logic signed [23:0]          vert_y,
    output sqv_pkg::side_t              side_out
);

    localparam int F  = TRIG_BITS - 2;
    localparam int PW = 25 + TRIG_BITS;
    localparam logic signed [PW:0] RND  = (PW+1)'(1) <<< (F - 1);
    localparam logic signed [PW:0] MAXV = (PW+1)'(8388607);
    localparam logic signed [PW:0] MINV = -(PW+1)'(8388608);

    logic en;
    logic r1_v_reg;
    logic ov_reg;
    logic signed [PW-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [23:0] cx_reg, cy_reg;
    sqv_pkg::side_t side_reg;

    logic signed [PW:0] sx, sy, rx, ry, tx, ty;
    logic signed [23:0] vx_next, vy_next;
    logic signed [23:0] vx_reg, vy_reg;
    sqv_pkg::side_t sideo_reg;

    assign en        = !ov_reg || out_ready;
    assign vin_ready = en;

    always_comb
    begin
        sx = (PW+1)'(xc_reg) - (PW+1)'(ys_reg);
        sy = (PW+1)'(xs_reg) + (PW+1)'(yc_reg);
        rx = (sx + RND) >>> F;
        ry = (sy + RND) >>> F;
        tx = rx + (PW+1)'(cx_reg);
        ty = ry + (PW+1)'(cy_reg);
        if (tx > MAXV)
            vx_next = 24'sh7FFFFF;
        else if (tx < MINV)
            vx_next = 24'sh800000;
        else
            vx_next = tx[23:0];
        if (ty > MAXV)
            vy_next = 24'sh7FFFFF;
        else if (ty < MINV)
            vy_next = 24'sh800000;
        else
            vy_next = ty[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else if (en)
        begin
            r1_v_reg <= vin_valid;
            ov_reg   <= r1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg    <= PW'(dx) * PW'(cos_v);
            ys_reg    <= PW'(dy) * PW'(sin_v);
            xs_reg    <= PW'(dx) * PW'(sin_v);
            yc_reg    <= PW'(dy) * PW'(cos_v);
            cx_reg    <= cx;
            cy_reg    <= cy;
            side_reg  <= side;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            sideo_reg <= side_reg;
        end
    end

    assign out_valid = ov_reg;
    assign vert_x    = vx_reg;
    assign vert_y    = vy_reg;
    assign side_out  = sideo_reg;

endmodule

>>> rtl/sprite_quad_vertex_gen.sv
// Channel   Direction  Handshake              Payload
// sprite    in         in_valid / in_ready    centre, size, pivot, angle, depth, tex, colour
// vertex    out        out_valid / out_ready  position, depth, tex u/v, colour, corner, last
//
// A visible sprite yields four vertex words, one per cycle while the output is not
// stalled, so the vertex serializer limits how often sprites go in.
// The first vertex of a sprite reaches the outputs through the front stages, the
// serializer register and the rotator's product and output registers.
// Invisible sprites are taken and dropped in the first stage.
// Reset clears only valid bits and the corner counter.
// A stalled output holds its word; the serializer and, once it is full, the front stop.
module sprite_quad_vertex_gen #(
    parameter int TRIG_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] centre_x,
    input  logic signed [23:0] centre_y,
    input  logic [23:0]        width,
    input  logic [23:0]        height,
    input  logic [16:0]        pivot_x,
    input  logic [16:0]        pivot_y,
    input  logic [15:0]        angle,
    input  logic [16:0]        depth_in,
    input  logic [31:0]        tex_top_left,
    input  logic [31:0]        tex_bottom_right,
    input  logic [31:0]        colour_in,
    input  logic               visible,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] vert_x,
    output logic signed [23:0] vert_y,
    output logic [16:0]        depth_out,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [31:0]        colour_out,
    output logic [1:0]         corner,
    output logic               last
);

    // Front stages: one setup stage, then six stages that run alongside the sine unit.
    localparam int NSTG = 6;

    logic en_f;
    logic en_r;
    logic [NSTG:0] v_reg;

    sqv_pkg::s1_t  s1_reg;
    sqv_pkg::s1_t  s1_next;
    logic [15:0]   ang_reg;
    logic [15:0]   ang_cos;
    sqv_pkg::spr_t spr_reg [NSTG];
    sqv_pkg::spr_t spr_next;

    logic [16:0] px_sat, py_sat;
    logic [41:0] wp, hp;

    logic signed [TRIG_BITS-1:0] sin_w, cos_w;

    // Serializer state.
    logic          ser_v_reg;
    logic [1:0]    cnt_reg;
    sqv_pkg::spr_t ser_reg;
    logic signed [TRIG_BITS-1:0] ser_s_reg, ser_c_reg;
    logic          ser_done;
    logic          hx, vy;
    sqv_pkg::side_t side_w, side_o;

    // The pivot offset rounds half up and stays within the sprite size.
    always_comb
    begin
        px_sat = (pivot_x > sqv_pkg::PIVOT_ONE) ? sqv_pkg::PIVOT_ONE : pivot_x;
        py_sat = (pivot_y > sqv_pkg::PIVOT_ONE) ? sqv_pkg::PIVOT_ONE : pivot_y;
        wp = 42'(width) * 42'(px_sat) + 42'd32768;
        hp = 42'(height) * 42'(py_sat) + 42'd32768;
        s1_next.cx    = centre_x;
        s1_next.cy    = centre_y;
        s1_next.w     = width;
        s1_next.h     = height;
        s1_next.ox    = wp[39:16];
        s1_next.oy    = hp[39:16];
        s1_next.depth = depth_in;
        s1_next.ttl   = tex_top_left;
        s1_next.tbr   = tex_bottom_right;
        s1_next.col   = colour_in;
    end

    always_comb
    begin
        spr_next.cx    = s1_reg.cx;
        spr_next.cy    = s1_reg.cy;
        spr_next.xl    = -$signed({1'b0, s1_reg.ox});
        spr_next.xr    = $signed({1'b0, s1_reg.w}) - $signed({1'b0, s1_reg.ox});
        spr_next.yt    = -$signed({1'b0, s1_reg.oy});
        spr_next.yb    = $signed({1'b0, s1_reg.h}) - $signed({1'b0, s1_reg.oy});
        spr_next.depth = s1_reg.depth;
        spr_next.ttl   = s1_reg.ttl;
        spr_next.tbr   = s1_reg.tbr;
        spr_next.col   = s1_reg.col;
    end

    // Cosine is the sine a quarter turn ahead.
    assign ang_cos = ang_reg + 16'd16384;

    sqv_sincos #(.TRIG_BITS(TRIG_BITS)) u_sin (
        .clk   (clk),
        .en    (en_f),
        .angle (ang_reg),
        .value (sin_w)
    );

    sqv_sincos #(.TRIG_BITS(TRIG_BITS)) u_cos (
        .clk   (clk),
        .en    (en_f),
        .angle (ang_cos),
        .value (cos_w)
    );

    // The front pipeline moves as one; it advances whenever the serializer
    // is free or hands off its last corner in this cycle.
    assign ser_done = ser_v_reg && en_r && (cnt_reg == sqv_pkg::CORNER_TR);
    assign en_f     = !ser_v_reg || ser_done;
    assign in_ready = en_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            ser_v_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (en_f)
            begin
                v_reg     <= {v_reg[NSTG-1:0], in_valid && visible};
                ser_v_reg <= v_reg[NSTG];
                cnt_reg   <= '0;
            end
            else if (ser_v_reg && en_r)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            s1_reg     <= s1_next;
            ang_reg    <= angle;
            spr_reg[0] <= spr_next;
            for (int i = 1; i < NSTG; i++)
            begin
                spr_reg[i] <= spr_reg[i-1];
            end
            ser_reg   <= spr_reg[NSTG-1];
            ser_s_reg <= sin_w;
            ser_c_reg <= cos_w;
        end
    end

    // Corner order top-left, bottom-left, bottom-right, top-right.
    assign hx = cnt_reg[1];
    assign vy = cnt_reg[1] ^ cnt_reg[0];

    always_comb
    begin
        side_w.depth  = ser_reg.depth;
        side_w.u      = hx ? ser_reg.tbr[31:16] : ser_reg.ttl[31:16];
        side_w.v      = vy ? ser_reg.tbr[15:0] : ser_reg.ttl[15:0];
        side_w.col    = ser_reg.col;
        side_w.corner = cnt_reg;
        side_w.last   = (cnt_reg == sqv_pkg::CORNER_TR);
    end

    sqv_rotate #(.TRIG_BITS(TRIG_BITS)) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .vin_valid (ser_v_reg),
        .vin_ready (en_r),
        .dx        (hx ? ser_reg.xr : ser_reg.xl),
        .dy        (vy ? ser_reg.yb : ser_reg.yt),
        .sin_v     (ser_s_reg),
        .cos_v     (ser_c_reg),
        .cx        (ser_reg.cx),
        .cy        (ser_reg.cy),
        .side      (side_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .side_out  (side_o)
    );

    assign depth_out  = side_o.depth;
    assign tex_u      = side_o.u;
    assign tex_v      = side_o.v;
    assign colour_out = side_o.col;
    assign corner     = side_o.corner;
    assign last       = side_o.last;

    // A sprite is only counted through while the serializer holds one.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ser_v_reg |=> (cnt_reg == 2'd0) || ser_v_reg)
        else $error("corner counter moved without a sprite");

    // The input is open whenever the serializer is empty.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !ser_v_reg |-> in_ready)
        else $error("input stalled with empty serializer");

    // Each new sprite starts on the top-left corner.
    a_start_tl: assert property (@(posedge clk) disable iff (!rst_n)
        en_f && v_reg[NSTG] |=> ser_v_reg && (cnt_reg == 2'd0))
        else $error("sprite did not start on the first corner");

    // A sprite leaves the serializer only after its last corner.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ser_v_reg && !ser_done |=> ser_v_reg)
        else $error("sprite dropped before its last corner");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for sprite_quad_vertex_gen.
// Every sprite word sent to the block is run through a local copy of the vertex
// math, and the four expected vertex words are queued. The checker process compares
// each accepted vertex word with the oldest queued vertex. Invisible sprites queue
// nothing. Both handshakes get random gaps and stalls, with one long run of neither.
module tb;

    // Corner codes in the order the block emits them.
    typedef enum logic [1:0] {
        CRN_TL = 2'd0,
        CRN_BL = 2'd1,
        CRN_BR = 2'd2,
        CRN_TR = 2'd3
    } corner_e;

    localparam int TRIG_FRAC = 14;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [23:0]        w;
        logic [23:0]        h;
        logic [16:0]        px;
        logic [16:0]        py;
        logic [15:0]        ang;
        logic [16:0]        depth;
        logic [31:0]        ttl;
        logic [31:0]        tbr;
        logic [31:0]        col;
        logic               vis;
    } sprite_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [16:0]        depth;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        col;
        logic [1:0]         crn;
        logic               lst;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [23:0] centre_x = '0;
    logic signed [23:0] centre_y = '0;
    logic [23:0] width = '0;
    logic [23:0] height = '0;
    logic [16:0] pivot_x = '0;
    logic [16:0] pivot_y = '0;
    logic [15:0] angle = '0;
    logic [16:0] depth_in = '0;
    logic [31:0] tex_top_left = '0;
    logic [31:0] tex_bottom_right = '0;
    logic [31:0] colour_in = '0;
    logic visible = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [16:0] depth_out;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] colour_out;
    logic [1:0] corner;
    logic last;

    vertex_t expected_vertices[$];
    int fail_count = 0;
    longint cycle_count = 0;
    // While set, neither side inserts gaps or stalls.
    bit no_idle = 1'b0;

    sprite_quad_vertex_gen dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .centre_x(centre_x),
        .centre_y(centre_y),
        .width(width),
        .height(height),
        .pivot_x(pivot_x),
        .pivot_y(pivot_y),
        .angle(angle),
        .depth_in(depth_in),
        .tex_top_left(tex_top_left),
        .tex_bottom_right(tex_bottom_right),
        .colour_in(colour_in),
        .visible(visible),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .vert_x(vert_x),
        .vert_y(vert_y),
        .depth_out(depth_out),
        .tex_u(tex_u),
        .tex_v(tex_v),
        .colour_out(colour_out),
        .corner(corner),
        .last(last)
    );

    always #2 clk = ~clk;

    // The watchdog ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Quarter-wave sine polynomial in Q30 with truncated products, clamped to
    // one and rounded half up to the trig fraction width.
    function automatic longint quarter_wave(longint unsigned k);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned coef[5];
        begin
            coef = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
                     64'd172272};
            t = k << 16;
            t2 = (t * t) >> 30;
            p = coef[4];
            for (int i = 3; i >= 0; i--)
                p = coef[i] - ((t2 * p) >> 30);
            p = (t * p) >> 30;
            if (p > (64'd1 << 30))
                p = 64'd1 << 30;
            return longint'((p + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
        end
    endfunction

    function automatic longint sine_of(logic [15:0] a);
        longint mag;
        begin
            mag = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
            return a[15] ? -mag : mag;
        end
    endfunction

    // Arithmetic shift with a half-up bias gives round half up for negatives too.
    function automatic longint round_trig(longint v);
        return (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 8388607)
            return 24'h7fffff;
        if (v < -8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    // Queues the four vertices that a sprite produces, or none if it is hidden.
    task automatic queue_quad_vertices(sprite_t s);
        longint unsigned pvx;
        longint unsigned pvy;
        longint ox;
        longint oy;
        longint xs[2];
        longint ys[2];
        longint sn;
        longint cs;
        longint dx;
        longint dy;
        int hx;
        int vy;
        vertex_t vtx;
        begin
            if (!s.vis)
                return;
            pvx = (s.px > 17'h10000) ? 64'h10000 : 64'(s.px);
            pvy = (s.py > 17'h10000) ? 64'h10000 : 64'(s.py);
            ox = longint'((64'(s.w) * pvx + 32768) >> 16);
            oy = longint'((64'(s.h) * pvy + 32768) >> 16);
            xs[0] = -ox;
            xs[1] = longint'(s.w) - ox;
            ys[0] = -oy;
            ys[1] = longint'(s.h) - oy;
            sn = sine_of(s.ang);
            cs = sine_of(s.ang + 16'd16384);
            for (int k = 0; k < 4; k++)
            begin
                hx = (k >= 2) ? 1 : 0;
                vy = (k == 1 || k == 2) ? 1 : 0;
                dx = xs[hx];
                dy = ys[vy];
                vtx.x = clamp24(longint'(s.cx) + round_trig(dx * cs - dy * sn));
                vtx.y = clamp24(longint'(s.cy) + round_trig(dx * sn + dy * cs));
                vtx.depth = s.depth;
                vtx.u = hx ? s.tbr[31:16] : s.ttl[31:16];
                vtx.v = vy ? s.tbr[15:0] : s.ttl[15:0];
                vtx.col = s.col;
                vtx.crn = 2'(k);
                vtx.lst = (k == CRN_TR);
                expected_vertices.push_back(vtx);
            end
        end
    endtask

    // Drives one sprite word, waits for its acceptance, then queues the
    // expected vertices. Valid stays up into the next word when no gap is drawn.
    task automatic send_sprite(sprite_t s);
        begin
            while (!no_idle && $urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            centre_x <= s.cx;
            centre_y <= s.cy;
            width <= s.w;
            height <= s.h;
            pivot_x <= s.px;
            pivot_y <= s.py;
            angle <= s.ang;
            depth_in <= s.depth;
            tex_top_left <= s.ttl;
            tex_bottom_right <= s.tbr;
            colour_in <= s.col;
            visible <= s.vis;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            queue_quad_vertices(s);
            @(negedge clk);
        end
    endtask

    function automatic sprite_t random_sprite();
        sprite_t s;
        begin
            s.cx = 24'($urandom);
            s.cy = 24'($urandom);
            // Mostly modest sizes so that rotated corners stay in range; some full range.
            s.w = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
            s.h = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
            s.px = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
            s.py = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
            s.ang = 16'($urandom);
            s.depth = 17'($urandom);
            s.ttl = $urandom;
            s.tbr = $urandom;
            s.col = $urandom;
            s.vis = ($urandom_range(9) != 0);
            return s;
        end
    endfunction

    task automatic wait_for_drain();
        begin
            in_valid <= 1'b0;
            while (expected_vertices.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    // Extremes of every field, each quadrant boundary, hidden sprites,
    // pivots above one, and positions that saturate both ways.
    task automatic test_directed();
        sprite_t s;
        logic [15:0] angs[8];
        begin
            angs = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h3fff, 16'h2000,
                     16'hffff, 16'h1234};
            for (int i = 0; i < 8; i++)
            begin
                s = random_sprite();
                s.vis = 1'b1;
                s.ang = angs[i];
                s.w = 24'h001000;
                s.h = 24'h000800;
                send_sprite(s);
            end
            // All-zero and all-ones words; the second saturates positions.
            s = '{default: '0};
            s.vis = 1'b1;
            send_sprite(s);
            s = '{cx: 24'h7fffff, cy: 24'h7fffff, w: 24'hffffff, h: 24'hffffff,
                  px: 17'h1ffff, py: 17'h1ffff, ang: 16'hffff, depth: 17'h1ffff,
                  ttl: 32'hffffffff, tbr: 32'hffffffff, col: 32'hffffffff, vis: 1'b1};
            send_sprite(s);
            s.cx = 24'h800000;
            s.cy = 24'h800000;
            s.px = 17'h0;
            s.py = 17'h0;
            s.ang = 16'h8000;
            send_sprite(s);
            s.px = 17'h10000;
            s.py = 17'h10001;
            s.ang = 16'h0000;
            send_sprite(s);
            // Hidden sprites give no vertices.
            s.vis = 1'b0;
            send_sprite(s);
            s = random_sprite();
            s.vis = 1'b0;
            send_sprite(s);
            s = random_sprite();
            s.vis = 1'b1;
            s.px = 17'h08000;
            s.py = 17'h08000;
            send_sprite(s);
            wait_for_drain();
        end
    endtask

    task automatic test_random(int count);
        begin
            for (int i = 0; i < count; i++)
                send_sprite(random_sprite());
        end
    endtask

    // Back-to-back words on both sides to reach full rate.
    task automatic test_full_rate(int count);
        begin
            no_idle = 1'b1;
            test_random(count);
            no_idle = 1'b0;
        end
    endtask

    // The sender holds off until every vertex has arrived, then resumes.
    task automatic test_pause_to_empty(int count);
        begin
            test_random(count);
            wait_for_drain();
            test_random(count);
        end
    endtask

    // Receiver: random stalls on out_ready, sampled at the rising edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle || ($urandom_range(99) >= 32);
    end

    // Vertex checker: every accepted vertex word against the oldest expectation.
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("vertex word with no expected vertex");
                fail_count++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                if (vert_x !== e.x)
                begin
                    $error("vert_x expected %0d actual %0d", e.x, vert_x);
                    fail_count++;
                end
                if (vert_y !== e.y)
                begin
                    $error("vert_y expected %0d actual %0d", e.y, vert_y);
                    fail_count++;
                end
                if (depth_out !== e.depth)
                begin
                    $error("depth_out expected %h actual %h", e.depth, depth_out);
                    fail_count++;
                end
                if (tex_u !== e.u)
                begin
                    $error("tex_u expected %h actual %h", e.u, tex_u);
                    fail_count++;
                end
                if (tex_v !== e.v)
                begin
                    $error("tex_v expected %h actual %h", e.v, tex_v);
                    fail_count++;
                end
                if (colour_out !== e.col)
                begin
                    $error("colour_out expected %h actual %h", e.col, colour_out);
                    fail_count++;
                end
                if (corner !== e.crn)
                begin
                    $error("corner expected %0d actual %0d", e.crn, corner);
                    fail_count++;
                end
                if (last !== e.lst)
                begin
                    $error("last expected %0d actual %0d", e.lst, last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(150);
        test_full_rate(100);
        test_pause_to_empty(70);
        test_random(100);
        wait_for_drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/sqv_pkg.sv
rtl/sqv_sincos.sv
rtl/sqv_rotate.sv
rtl/sprite_quad_vertex_gen.sv
tb/tb.sv
